/* design/rlfwd_pkg.sv */
// Shared constants, types and helpers for the run-length FIFO with weighted drain.
`timescale 1ns / 1ps

package rlfwd_pkg;

    localparam int RUN_DEPTH = 1024;
    localparam int PTR_W     = (RUN_DEPTH > 1) ? $clog2(RUN_DEPTH) : 1;
    localparam int OCC_W     = $clog2(RUN_DEPTH + 1);
    localparam int VAL_W     = 30;
    localparam int CNT_W     = 30;
    localparam int SUM_W     = 60;
    localparam int ENTRY_W   = VAL_W + CNT_W;

    localparam logic       REQ_PUSH = 1'b0;
    localparam logic       REQ_TAKE = 1'b1;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

    // One operation for the multiply-accumulate unit.
    typedef struct packed {
        logic             clear;
        logic             valid;
        logic [VAL_W-1:0] value;
        logic [CNT_W-1:0] units;
    } mac_cmd_t;

    // Advance a ring pointer with wrap at the last slot.
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(RUN_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

endpackage

/* design/rlfwd_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module rlfwd_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/rlfwd_mac.sv */
// Multiply-accumulate unit for the drained sum, with operand and product stages ahead of the accumulator.
`timescale 1ns / 1ps

module rlfwd_mac (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  rlfwd_pkg::mac_cmd_t      cmd,
    output logic                     busy,
    output logic [rlfwd_pkg::SUM_W-1:0] acc
);

    logic                          op_vld_reg;
    logic [rlfwd_pkg::VAL_W-1:0]   op_value_reg;
    logic [rlfwd_pkg::CNT_W-1:0]   op_units_reg;
    logic                          prod_vld_reg;
    logic [rlfwd_pkg::SUM_W-1:0]   prod_reg;
    logic [rlfwd_pkg::SUM_W-1:0]   acc_reg;

    // Control valids.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            op_vld_reg   <= cmd.valid;
            prod_vld_reg <= op_vld_reg;
        end
    end

    // Operand stage, product stage, accumulate.
    always_ff @(posedge aclk) begin
        if (cmd.valid) begin
            op_value_reg <= cmd.value;
            op_units_reg <= cmd.units;
        end
        if (op_vld_reg) begin
            prod_reg <= rlfwd_pkg::SUM_W'(op_value_reg) * rlfwd_pkg::SUM_W'(op_units_reg);
        end
        if (cmd.clear) begin
            acc_reg <= '0;
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + prod_reg;
        end
    end

    assign busy = op_vld_reg | prod_vld_reg;
    assign acc  = acc_reg;

endmodule

/* design/run_length_fifo_weighted_drain.sv */
// Top level: run-length FIFO with weighted drain, request control and result register.
// Push: result is in the output register in the cycle after the request is accepted.
// Take: each run visited costs a RAM read, then an evaluate step; the walk then waits for the
//   multiply-accumulate pipe to drain and the output register to be free before answering.
//   Zero-unit takes and takes from an empty store answer in the cycle after accept, like a push.
// One request in flight at a time; the run store's registered read sets the walk pace.
// Reset clears pointers, occupancy and control; the run store is not cleared.
`timescale 1ns / 1ps

module run_length_fifo_weighted_drain (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_req_type,
    input  logic [rlfwd_pkg::VAL_W-1:0]       s_run_value,
    input  logic [rlfwd_pkg::CNT_W-1:0]       s_unit_count,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rlfwd_pkg::SUM_W-1:0]       m_drained_sum,
    output logic [1:0]                        m_status
);

    // Controller states.
    localparam logic [1:0] S_IDLE = 2'd0;  // wait for a request
    localparam logic [1:0] S_READ = 2'd1;  // present head address to the run store
    localparam logic [1:0] S_EVAL = 2'd2;  // consume or split the head run
    localparam logic [1:0] S_FIN  = 2'd3;  // wait for the MAC pipe and a free output, then post result

    logic [1:0]                        state_reg, state_next;
    logic [rlfwd_pkg::PTR_W-1:0]       head_reg, head_next;
    logic [rlfwd_pkg::PTR_W-1:0]       tail_reg, tail_next;
    logic [rlfwd_pkg::OCC_W-1:0]       occ_reg, occ_next;
    logic [rlfwd_pkg::CNT_W-1:0]       left_reg, left_next;
    logic [1:0]                        take_status_reg, take_status_next;

    logic                              m_valid_reg, m_valid_next;
    logic [rlfwd_pkg::SUM_W-1:0]       m_sum_reg, m_sum_next;
    logic [1:0]                        m_status_reg, m_status_next;

    logic                              wr_en;
    logic [rlfwd_pkg::PTR_W-1:0]       wr_addr;
    logic [rlfwd_pkg::ENTRY_W-1:0]     wr_data;
    logic                              rd_en;
    logic [rlfwd_pkg::ENTRY_W-1:0]     rd_data;
    logic [rlfwd_pkg::VAL_W-1:0]       rd_value;
    logic [rlfwd_pkg::CNT_W-1:0]       rd_count;

    rlfwd_pkg::mac_cmd_t               mac_cmd;
    logic                              mac_busy;
    logic [rlfwd_pkg::SUM_W-1:0]       mac_acc;

    logic                              out_free;
    logic                              accept;
    logic                              split;
    logic [rlfwd_pkg::CNT_W-1:0]       left_after;
    logic [rlfwd_pkg::OCC_W-1:0]       occ_after;

    // The output register frees when empty or when its result is being taken.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE) && out_free;
    assign accept   = s_valid && s_ready;

    assign rd_value = rd_data[rlfwd_pkg::ENTRY_W-1:rlfwd_pkg::CNT_W];
    assign rd_count = rd_data[rlfwd_pkg::CNT_W-1:0];

    // A split leaves part of the head run in place; otherwise the whole run goes.
    assign split      = rd_count > left_reg;
    assign left_after = left_reg - rd_count;
    assign occ_after  = occ_reg - 1'b1;

    assign rd_en = (state_reg == S_READ);

    rlfwd_ram #(
        .DATA_W (rlfwd_pkg::ENTRY_W),
        .DEPTH  (rlfwd_pkg::RUN_DEPTH),
        .ADDR_W (rlfwd_pkg::PTR_W)
    ) u_run_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (rd_data)
    );

    rlfwd_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (mac_cmd),
        .busy    (mac_busy),
        .acc     (mac_acc)
    );

    always_comb begin
        state_next       = state_reg;
        head_next        = head_reg;
        tail_next        = tail_reg;
        occ_next         = occ_reg;
        left_next        = left_reg;
        take_status_next = take_status_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_sum_next       = m_sum_reg;
        m_status_next    = m_status_reg;
        wr_en            = 1'b0;
        wr_addr          = tail_reg;
        wr_data          = {s_run_value, s_unit_count};
        mac_cmd          = '0;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    if (s_req_type == rlfwd_pkg::REQ_PUSH) begin
                        // Push answers at once; an empty run stores nothing.
                        m_valid_next  = 1'b1;
                        m_sum_next    = '0;
                        m_status_next = rlfwd_pkg::STATUS_OK;
                        if (s_unit_count != '0) begin
                            if (occ_reg == rlfwd_pkg::OCC_W'(rlfwd_pkg::RUN_DEPTH)) begin
                                m_status_next = rlfwd_pkg::STATUS_FULL;
                            end else begin
                                wr_en     = 1'b1;
                                tail_next = rlfwd_pkg::ptr_inc(tail_reg);
                                occ_next  = occ_reg + 1'b1;
                            end
                        end
                    end else if (s_unit_count == '0) begin
                        m_valid_next  = 1'b1;
                        m_sum_next    = '0;
                        m_status_next = rlfwd_pkg::STATUS_OK;
                    end else if (occ_reg == '0) begin
                        m_valid_next  = 1'b1;
                        m_sum_next    = '0;
                        m_status_next = rlfwd_pkg::STATUS_UNDERFLOW;
                    end else begin
                        // Start the walk: clear the accumulator and read the head.
                        mac_cmd.clear    = 1'b1;
                        left_next        = s_unit_count;
                        take_status_next = rlfwd_pkg::STATUS_OK;
                        state_next       = S_READ;
                    end
                end
            end
            S_READ: begin
                state_next = S_EVAL;
            end
            S_EVAL: begin
                mac_cmd.valid = 1'b1;
                mac_cmd.value = rd_value;
                if (split) begin
                    // Lower the head run's count and stop.
                    mac_cmd.units = left_reg;
                    wr_en         = 1'b1;
                    wr_addr       = head_reg;
                    wr_data       = {rd_value, rd_count - left_reg};
                    left_next     = '0;
                    state_next    = S_FIN;
                end else begin
                    // Drop the whole head run.
                    mac_cmd.units = rd_count;
                    left_next     = left_after;
                    head_next     = rlfwd_pkg::ptr_inc(head_reg);
                    occ_next      = occ_after;
                    if (left_after == '0) begin
                        state_next = S_FIN;
                    end else if (occ_after == '0) begin
                        take_status_next = rlfwd_pkg::STATUS_UNDERFLOW;
                        state_next       = S_FIN;
                    end else begin
                        state_next = S_READ;
                    end
                end
            end
            S_FIN: begin
                // Hold until the last product is accumulated and the output is free.
                if (!mac_busy && out_free) begin
                    m_valid_next  = 1'b1;
                    m_sum_next    = mac_acc;
                    m_status_next = take_status_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            occ_reg     <= occ_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        left_reg        <= left_next;
        take_status_reg <= take_status_next;
        m_sum_reg       <= m_sum_next;
        m_status_reg    <= m_status_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_drained_sum = m_sum_reg;
    assign m_status      = m_status_reg;

    // Occupancy stays within the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg <= rlfwd_pkg::OCC_W'(rlfwd_pkg::RUN_DEPTH))
        else $error("occupancy beyond store depth");

    // An empty store has its pointers together.
    assert property (@(posedge aclk) disable iff (!aresetn)
        occ_reg == '0 |-> head_reg == tail_reg)
        else $error("empty store with pointers apart");

    // Every run visited by a take holds a nonzero count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_EVAL |-> rd_count != '0)
        else $error("zero-count run in store");

    // A take in progress never grows the store.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != S_IDLE |=> occ_reg <= $past(occ_reg))
        else $error("occupancy grew during a take");

    // A result is posted only when the MAC pipe is empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_FIN && state_next == S_IDLE |-> !mac_busy)
        else $error("result posted with MAC busy");

endmodule
